>>> src/assert_macros.svh
// Assertion macros for the RTL of the MIDI message parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while reset is asserted.
`define MMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising edge of clk.
`define MMP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/mmp_pkg.sv
// Types and constants of the MIDI message parser.
package mmp_pkg;

	// Note event store
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Status byte decode: upper nibble selects the message, channel ignored
	localparam logic [7:0] MSG_TYPE_MASK = 8'hF0;
	localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
	localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
	localparam logic [7:0] MSG_CTRL      = 8'hB0;
	localparam logic [7:0] MSG_BEND      = 8'hE0;

	localparam logic [13:0] BEND_CENTER = 14'd8192;

	typedef enum logic [1:0] {
		REQ_BYTE = 2'd0,
		REQ_POP  = 2'd1,
		REQ_CTRL = 2'd2
	} mmp_req_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2
	} mmp_status_t;

	typedef enum logic [2:0] {
		PS_IDLE     = 3'd0,
		PS_NOTE_OFF = 3'd1,
		PS_NOTE_ON  = 3'd2,
		PS_CTRL     = 3'd3,
		PS_BEND     = 3'd4
	} mmp_parse_state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [6:0] ctrl_select;
	} mmp_req_item_t;

	typedef struct packed {
		logic        event_valid;
		logic [6:0]  event_key;
		logic        event_is_on;
		logic [6:0]  event_velocity;
		logic [6:0]  ctrl_value;
		logic [13:0] bend_value;
		logic [1:0]  fifo_status;
		logic [4:0]  fifo_count;
	} mmp_rsp_item_t;

	// One stored note event
	typedef struct packed {
		logic [6:0] velocity;
		logic       is_on;
		logic [6:0] key;
	} mmp_event_t;

	// Actions the parser raises on a completed message
	typedef struct packed {
		logic       push;
		mmp_event_t push_event;
		logic       ctrl_we;
		logic [6:0] ctrl_addr;
		logic [6:0] ctrl_data;
	} mmp_action_t;

endpackage

>>> src/mmp_parser.sv
// Byte parser: message state machine, pending data bytes and pitch bend register.
module mmp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_we,
	input  logic [13:0]          cfg_wdata,
	output mmp_pkg::mmp_action_t action,
	output logic [13:0]          bend_next
);
	import mmp_pkg::*;

	mmp_parse_state_t state_q, state_d;
	logic             data_idx_q, data_idx_d;
	logic [6:0]       pend_key_q, pend_key_d;
	logic             pend_on_q, pend_on_d;
	logic [6:0]       pend_ctrl_q, pend_ctrl_d;
	logic [6:0]       bend_low_q, bend_low_d;
	logic [13:0]      bend_q;
	logic [6:0]       data7;

	assign data7 = rx_byte[6:0];

	// Next state
	always_comb begin
		state_d = state_q;
		if (byte_en) begin
			case (state_q)
				PS_IDLE: begin
					case (rx_byte & MSG_TYPE_MASK)
						MSG_NOTE_OFF: state_d = PS_NOTE_OFF;
						MSG_NOTE_ON:  state_d = PS_NOTE_ON;
						MSG_CTRL:     state_d = PS_CTRL;
						MSG_BEND:     state_d = PS_BEND;
						default:      state_d = PS_IDLE;
					endcase
				end
				PS_NOTE_OFF, PS_NOTE_ON, PS_CTRL, PS_BEND: begin
					if (data_idx_q) state_d = PS_IDLE;
				end
				default: state_d = PS_IDLE;
			endcase
		end
	end

	// Data capture and actions; any byte inside a message is data
	always_comb begin
		data_idx_d  = data_idx_q;
		pend_key_d  = pend_key_q;
		pend_on_d   = pend_on_q;
		pend_ctrl_d = pend_ctrl_q;
		bend_low_d  = bend_low_q;
		bend_next   = bend_q;
		action      = '0;
		if (byte_en) begin
			case (state_q)
				PS_IDLE: data_idx_d = 1'b0;
				PS_NOTE_OFF, PS_NOTE_ON: begin
					if (!data_idx_q) begin
						pend_key_d = data7;
						pend_on_d  = (state_q == PS_NOTE_ON);
						data_idx_d = 1'b1;
					end else begin
						action.push                = 1'b1;
						action.push_event.key      = pend_key_q;
						action.push_event.is_on    = pend_on_q;
						action.push_event.velocity = data7;
						data_idx_d                 = 1'b0;
					end
				end
				PS_CTRL: begin
					if (!data_idx_q) begin
						pend_ctrl_d = data7;
						data_idx_d  = 1'b1;
					end else begin
						action.ctrl_we   = 1'b1;
						action.ctrl_addr = pend_ctrl_q;
						action.ctrl_data = data7;
						data_idx_d       = 1'b0;
					end
				end
				PS_BEND: begin
					if (!data_idx_q) begin
						bend_low_d = data7;
						data_idx_d = 1'b1;
					end else begin
						bend_next  = {data7, bend_low_q};
						data_idx_d = 1'b0;
					end
				end
				default: data_idx_d = 1'b0;
			endcase
		end
	end

	// Parser registers; a config write reloads the bend value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PS_IDLE;
			data_idx_q  <= 1'b0;
			pend_key_q  <= '0;
			pend_on_q   <= 1'b0;
			pend_ctrl_q <= '0;
			bend_low_q  <= '0;
			bend_q      <= BEND_CENTER;
		end else begin
			state_q     <= state_d;
			data_idx_q  <= data_idx_d;
			pend_key_q  <= pend_key_d;
			pend_on_q   <= pend_on_d;
			pend_ctrl_q <= pend_ctrl_d;
			bend_low_q  <= bend_low_d;
			if (cfg_we) begin
				bend_q <= cfg_wdata;
			end else begin
				bend_q <= bend_next;
			end
		end
	end

endmodule

>>> src/mmp_event_fifo.sv
// Note event FIFO with registered read port and status tracking.
module mmp_event_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         push,
	input  mmp_pkg::mmp_event_t          push_event,
	input  logic                         pop,
	output mmp_pkg::mmp_event_t          pop_event,
	output logic [mmp_pkg::CNT_W-1:0]    count_next,
	output logic [1:0]                   status_next
);
	import mmp_pkg::*;

	mmp_event_t           mem [FIFO_DEPTH];
	mmp_event_t           rd_data_q;
	logic                 hit_q;
	logic [PTR_W-1:0]     rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [1:0]           status_q;
	logic                 full, empty, push_ok, pop_ok;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = en && push && !full;
	assign pop_ok  = en && pop && !empty;

	// Count and status after this request
	always_comb begin
		count_next  = count_q;
		status_next = status_q;
		if (en && push) begin
			status_next = full ? STAT_OVERFLOW : STAT_OK;
		end
		if (en && pop) begin
			status_next = empty ? STAT_EMPTY : STAT_OK;
		end
		if (push_ok) count_next = count_q + 1'b1;
		if (pop_ok)  count_next = count_q - 1'b1;
	end

	// Storage: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (push_ok) mem[wr_ptr_q] <= push_event;
		if (pop_ok)  rd_data_q     <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			status_q <= STAT_OK;
			hit_q    <= 1'b0;
		end else begin
			count_q  <= count_next;
			status_q <= status_next;
			if (en) hit_q <= pop_ok;
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	// Fields read as zero unless the last accepted request popped a stored event
	assign pop_event = hit_q ? rd_data_q : '0;

endmodule

>>> src/mmp_ctrl_table.sv
// Controller value table: 128 entries, per-entry valid bits cleared at reset.
module mmp_ctrl_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       we,
	input  logic [6:0] waddr,
	input  logic [6:0] wdata,
	input  logic       re,
	input  logic [6:0] raddr,
	output logic [6:0] rdata
);
	localparam int DEPTH = 128;

	logic [6:0]       mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [6:0]       rd_data_q;
	logic             hit_q;

	// Storage with registered read
	always_ff @(posedge clk) begin
		if (we)      mem[waddr] <= wdata;
		if (en && re) rd_data_q <= mem[raddr];
	end

	// An entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (we) written_q[waddr] <= 1'b1;
			if (en) hit_q <= re && written_q[raddr];
		end
	end

	assign rdata = hit_q ? rd_data_q : '0;

endmodule

>>> src/midi_message_parser.sv
// Top level of the MIDI message parser.
//
// Request channel (req_valid, req_stall, req): each transfer carries one
// request: a received MIDI byte, a note event pop or a controller read.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, in order, with the popped event, controller value, current
// pitch bend, FIFO status and FIFO fill count after that request.
// A request taken at one edge is shown on rsp in the cycle after.
// Throughput is one request per cycle while req_stall is low; the single
// response register is refilled in the same cycle it is taken, so req_stall
// only rises while a response waits and rsp_stall is high.
// A stalled response holds its value; state is not touched meanwhile.
// cfg_we/cfg_wdata load the pitch bend value; write only while no
// request is outstanding.
// Reset (arst_n low) clears the parser, empties the event FIFO, marks all
// controllers zero and sets pitch bend to the center value 8192.
module midi_message_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  mmp_pkg::mmp_req_item_t req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output mmp_pkg::mmp_rsp_item_t rsp,
	input  logic                   cfg_we,
	input  logic [13:0]            cfg_wdata
);
	import mmp_pkg::*;

	`include "assert_macros.svh"

	logic              accept;
	logic              is_byte, is_pop, is_ctrl;
	mmp_action_t       action;
	logic [13:0]       bend_next;
	mmp_event_t        pop_event;
	logic [CNT_W-1:0]  count_next;
	logic [1:0]        status_next;
	logic [6:0]        ctrl_rdata;
	logic              rsp_valid_q;
	logic [13:0]       bend_s1;
	logic [1:0]        status_s1;
	logic [CNT_W-1:0]  count_s1;
	logic              pop_hit_s1;

	// Handshake: take a request unless a response is held back
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_byte = (req.req_type == REQ_BYTE);
	assign is_pop  = (req.req_type == REQ_POP);
	assign is_ctrl = (req.req_type == REQ_CTRL);

	mmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (accept && is_byte),
		.rx_byte   (req.rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.action    (action),
		.bend_next (bend_next)
	);

	mmp_event_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.push        (action.push),
		.push_event  (action.push_event),
		.pop         (is_pop),
		.pop_event   (pop_event),
		.count_next  (count_next),
		.status_next (status_next)
	);

	mmp_ctrl_table u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.we     (action.ctrl_we),
		.waddr  (action.ctrl_addr),
		.wdata  (action.ctrl_data),
		.re     (is_ctrl),
		.raddr  (req.ctrl_select),
		.rdata  (ctrl_rdata)
	);

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bend_s1   <= bend_next;
			status_s1 <= status_next;
			count_s1  <= count_next;
		end
	end

	// Pop that returned a stored event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_hit_s1 <= 1'b0;
		end else if (accept) begin
			pop_hit_s1 <= is_pop && (status_next == STAT_OK);
		end
	end

	assign rsp_valid           = rsp_valid_q;
	assign rsp.event_valid     = pop_hit_s1;
	assign rsp.event_key       = pop_event.key;
	assign rsp.event_is_on     = pop_event.is_on;
	assign rsp.event_velocity  = pop_event.velocity;
	assign rsp.ctrl_value      = ctrl_rdata;
	assign rsp.bend_value      = bend_s1;
	assign rsp.fifo_status     = status_s1;
	assign rsp.fifo_count      = 5'(count_s1);

	// Checks
	`MMP_ASSERT_IMP(a_count_range, rsp_valid,
		rsp.fifo_count <= 5'(FIFO_DEPTH), "fifo count above depth")
	`MMP_ASSERT_IMP(a_event_ok, rsp_valid && rsp.event_valid,
		rsp.fifo_status == STAT_OK, "event returned without ok status")
	`MMP_ASSERT_IMP(a_empty_status, rsp_valid && rsp.fifo_status == STAT_EMPTY,
		rsp.fifo_count == '0 && !rsp.event_valid, "empty status with stored events")
	`MMP_ASSERT_IMP(a_overflow_full, rsp_valid && rsp.fifo_status == STAT_OVERFLOW,
		rsp.fifo_count == 5'(FIFO_DEPTH), "overflow status while not full")

endmodule
